// ===== hw/rtl/robin_hood_ordered_hash_table_core_defines.svh =====
// Assertion macros for the ordered hash table.
`ifndef ROBIN_HOOD_ORDERED_HASH_TABLE_CORE_DEFINES_SVH
`define ROBIN_HOOD_ORDERED_HASH_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RH_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RH_ASSERT(label, clk, rst, prop, msg)
`define RH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/rhoht_pkg.sv =====
package rhoht_pkg;
  localparam int KEY_W = 64;
  localparam int HASH_W = 32;
  localparam int VAL_W = 64;
  localparam int IDX_OUT_W = 8;

  typedef enum logic [1:0] {
    REQ_PUT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_REMOVED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_EV,
    S_FIND_CMP,
    S_PUT_HIT,
    S_PUT_NEW,
    S_PACK_RD,
    S_PACK_EV,
    S_PACK_CLR,
    S_REB_RD,
    S_REB_EV,
    S_APPEND,
    S_PLACE_RD,
    S_PLACE_EV,
    S_DEL_RD,
    S_DEL_EV,
    S_CLEAR,
    S_OUT
  } state_t;
endpackage

// ===== hw/rtl/rhoht_req_if.sv =====
interface rhoht_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [63:0] key;
  logic [31:0] key_hash;
  logic [63:0] value;
  modport source(output valid, req_type, key, key_hash, value, input ready);
  modport sink(input valid, req_type, key, key_hash, value, output ready);
endinterface

// ===== hw/rtl/rhoht_rsp_if.sv =====
interface rhoht_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [7:0] entry_index;
  logic [63:0] old_value;
  modport source(output valid, status, entry_index, old_value, input ready);
  modport sink(input valid, status, entry_index, old_value, output ready);
endinterface

// ===== hw/rtl/robin_hood_ordered_hash_table_core.sv =====
// Ordered hash map with Robin Hood probing and backward-shift removal. One request
// at a time; the next request word is taken only after the result word has left.
// The lookup reads one bucket at a time and compares the key of each bucket that
// does not end it. Placement and the backward shift also go one bucket at a time,
// a read and then an evaluate that writes the bucket memory. A clear empties every
// bucket in turn. A put that finds the append slots used up first packs the entry
// arrays in order, then empties the buckets in a second pass, and last places each
// kept entry again by a placement walk from its hash. After reset a clearing pass
// empties the buckets; no request is taken meanwhile.
`include "robin_hood_ordered_hash_table_core_defines.svh"
module robin_hood_ordered_hash_table_core #(
  parameter int ENTRY_SLOTS = 256,
  parameter int BUCKET_COUNT = 512
) (
  input logic clk,
  input logic rst,
  rhoht_req_if.sink req,
  rhoht_rsp_if.source rsp
);
  localparam int EW = $clog2(ENTRY_SLOTS);
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int CW = EW + 1;
  localparam int DW = BW + 1;
  localparam int MW = (CW > DW) ? CW : DW;

  typedef struct packed {
    logic valid;
    logic [DW-1:0] probe;
    logic [EW-1:0] idx;
  } bkt_t;

  bkt_t bmem [BUCKET_COUNT];
  logic [rhoht_pkg::KEY_W-1:0] kmem [ENTRY_SLOTS];
  logic [rhoht_pkg::VAL_W-1:0] vmem [ENTRY_SLOTS];
  logic [rhoht_pkg::HASH_W-1:0] hmem [ENTRY_SLOTS];
  logic [ENTRY_SLOTS-1:0] live;

  rhoht_pkg::state_t state, state_next;
  logic [1:0] rq;
  logic [rhoht_pkg::KEY_W-1:0] rkey;
  logic [rhoht_pkg::HASH_W-1:0] rhash;
  logic [rhoht_pkg::VAL_W-1:0] rval;
  logic [CW-1:0] append_slot;
  logic [CW-1:0] live_count;
  logic [BW-1:0] pos;
  logic [BW-1:0] prev;
  logic [DW-1:0] d;
  logic [DW-1:0] n;
  logic [EW-1:0] cidx;
  logic rebuilding;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  bkt_t bq;
  logic [rhoht_pkg::KEY_W-1:0] kq;
  logic [rhoht_pkg::VAL_W-1:0] vq;
  logic [rhoht_pkg::HASH_W-1:0] hq;
  logic [EW-1:0] eaddr;
  logic [2:0] o_status;
  logic [rhoht_pkg::IDX_OUT_W-1:0] o_idx;
  logic [rhoht_pkg::VAL_W-1:0] o_old;

  logic bwe;
  logic [BW-1:0] bwa;
  bkt_t bwd;
  logic [BW-1:0] bra;

  logic key_hit;
  logic room_full;
  assign key_hit = (hq == rhash) && (kq == rkey);
  assign room_full = (live_count >= CW'(ENTRY_SLOTS)) ||
                     (MW'(live_count) >= MW'(BUCKET_COUNT));

  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[bwa] <= bwd;
    end
    bq <= bmem[bra];
  end

  always_ff @(posedge clk) begin
    kq <= kmem[eaddr];
    vq <= vmem[eaddr];
    hq <= hmem[eaddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      rhoht_pkg::S_INIT: if (pos == BW'(BUCKET_COUNT - 1)) state_next = rhoht_pkg::S_IDLE;
      rhoht_pkg::S_IDLE: if (req.valid) state_next = rhoht_pkg::S_DECODE;
      rhoht_pkg::S_DECODE: begin
        case (rq)
          rhoht_pkg::REQ_PUT: state_next = rhoht_pkg::S_FIND_RD;
          rhoht_pkg::REQ_REMOVE: state_next = (live_count == '0) ? rhoht_pkg::S_OUT
                                                                 : rhoht_pkg::S_FIND_RD;
          rhoht_pkg::REQ_CLEAR: state_next = rhoht_pkg::S_CLEAR;
          default: state_next = rhoht_pkg::S_OUT;
        endcase
      end
      rhoht_pkg::S_FIND_RD: state_next = rhoht_pkg::S_FIND_EV;
      rhoht_pkg::S_FIND_EV: begin
        if (!bq.valid || d > bq.probe || n == DW'(BUCKET_COUNT)) begin
          state_next = (rq == rhoht_pkg::REQ_PUT) ? rhoht_pkg::S_PUT_NEW : rhoht_pkg::S_OUT;
        end else begin
          state_next = rhoht_pkg::S_FIND_CMP;
        end
      end
      rhoht_pkg::S_FIND_CMP: begin
        if (key_hit) begin
          state_next = (rq == rhoht_pkg::REQ_PUT) ? rhoht_pkg::S_PUT_HIT : rhoht_pkg::S_DEL_RD;
        end else begin
          state_next = rhoht_pkg::S_FIND_RD;
        end
      end
      rhoht_pkg::S_PUT_HIT: state_next = rhoht_pkg::S_OUT;
      rhoht_pkg::S_PUT_NEW: begin
        if (room_full) state_next = rhoht_pkg::S_OUT;
        else if (append_slot >= CW'(ENTRY_SLOTS)) state_next = rhoht_pkg::S_PACK_RD;
        else state_next = rhoht_pkg::S_APPEND;
      end
      rhoht_pkg::S_PACK_RD: state_next = rhoht_pkg::S_PACK_EV;
      rhoht_pkg::S_PACK_EV: begin
        if (rd == CW'(ENTRY_SLOTS - 1) || rd + 1'b1 >= append_slot) begin
          state_next = rhoht_pkg::S_PACK_CLR;
        end else begin
          state_next = rhoht_pkg::S_PACK_RD;
        end
      end
      rhoht_pkg::S_PACK_CLR: if (pos == BW'(BUCKET_COUNT - 1)) begin
        state_next = (wr == '0) ? rhoht_pkg::S_APPEND : rhoht_pkg::S_REB_RD;
      end
      rhoht_pkg::S_REB_RD: state_next = rhoht_pkg::S_REB_EV;
      rhoht_pkg::S_REB_EV: state_next = rhoht_pkg::S_PLACE_RD;
      rhoht_pkg::S_APPEND: state_next = rhoht_pkg::S_PLACE_RD;
      rhoht_pkg::S_PLACE_RD: state_next = rhoht_pkg::S_PLACE_EV;
      rhoht_pkg::S_PLACE_EV: begin
        if (!bq.valid || n == DW'(BUCKET_COUNT - 1)) begin
          if (rebuilding) begin
            state_next = (rd + 1'b1 == wr) ? rhoht_pkg::S_APPEND : rhoht_pkg::S_REB_RD;
          end else begin
            state_next = rhoht_pkg::S_OUT;
          end
        end else begin
          state_next = rhoht_pkg::S_PLACE_RD;
        end
      end
      rhoht_pkg::S_DEL_RD: state_next = rhoht_pkg::S_DEL_EV;
      rhoht_pkg::S_DEL_EV: begin
        if (!bq.valid || bq.probe == '0 || n == DW'(BUCKET_COUNT)) begin
          state_next = rhoht_pkg::S_OUT;
        end else begin
          state_next = rhoht_pkg::S_DEL_RD;
        end
      end
      rhoht_pkg::S_CLEAR: if (pos == BW'(BUCKET_COUNT - 1)) state_next = rhoht_pkg::S_OUT;
      rhoht_pkg::S_OUT: if (rsp.ready) state_next = rhoht_pkg::S_IDLE;
      default: state_next = rhoht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    bwe = 1'b0;
    bwa = pos;
    bwd = '0;
    bra = pos;
    eaddr = bq.idx;
    case (state)
      rhoht_pkg::S_INIT, rhoht_pkg::S_CLEAR, rhoht_pkg::S_PACK_CLR: bwe = 1'b1;
      rhoht_pkg::S_PACK_RD: eaddr = rd[EW-1:0];
      rhoht_pkg::S_REB_RD: eaddr = rd[EW-1:0];
      rhoht_pkg::S_PLACE_EV: begin
        if (!bq.valid || bq.probe < d) begin
          bwe = 1'b1;
          bwd.valid = 1'b1;
          bwd.probe = d;
          bwd.idx = cidx;
        end
      end
      rhoht_pkg::S_FIND_CMP: begin
        bwe = key_hit && (rq == rhoht_pkg::REQ_REMOVE);
      end
      rhoht_pkg::S_DEL_EV: begin
        if (bq.valid && bq.probe != '0 && n != DW'(BUCKET_COUNT)) begin
          bwe = 1'b1;
          bwa = prev;
          bwd.valid = 1'b1;
          bwd.probe = bq.probe - 1'b1;
          bwd.idx = bq.idx;
        end
      end
      rhoht_pkg::S_DEL_RD: begin
        bwe = (n != DW'(1));
        bwa = prev;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      append_slot <= '0;
      live_count <= '0;
      pos <= '0;
      rebuilding <= 1'b0;
    end else begin
      case (state)
        rhoht_pkg::S_IDLE: begin
          if (req.valid) begin
            rq <= req.req_type;
            rkey <= req.key;
            rhash <= req.key_hash;
            rval <= req.value;
            o_status <= rhoht_pkg::ST_NOT_FOUND;
            o_idx <= '0;
            o_old <= '0;
            d <= '0;
            n <= '0;
            pos <= req.key_hash[BW-1:0];
          end
        end
        rhoht_pkg::S_DECODE: if (rq == rhoht_pkg::REQ_CLEAR) pos <= '0;
        rhoht_pkg::S_FIND_CMP: begin
          if (key_hit) begin
            o_idx <= rhoht_pkg::IDX_OUT_W'({{(EW < 8 ? 8 - EW : 0){1'b0}}, bq.idx});
            cidx <= bq.idx;
            o_old <= vq;
            if (rq == rhoht_pkg::REQ_PUT) begin
              o_status <= rhoht_pkg::ST_REPLACED;
            end else begin
              o_status <= rhoht_pkg::ST_REMOVED;
              live[bq.idx] <= 1'b0;
              live_count <= live_count - 1'b1;
              prev <= pos;
              pos <= pos + 1'b1;
              n <= DW'(1);
            end
          end else begin
            d <= d + 1'b1;
            n <= n + 1'b1;
            pos <= pos + 1'b1;
          end
        end
        rhoht_pkg::S_PUT_HIT: vmem[cidx] <= rval;
        rhoht_pkg::S_PUT_NEW: begin
          if (room_full) o_status <= rhoht_pkg::ST_FULL;
          rd <= '0;
          wr <= '0;
          pos <= '0;
        end
        rhoht_pkg::S_PACK_EV: begin
          if (live[rd[EW-1:0]]) begin
            kmem[wr[EW-1:0]] <= kq;
            vmem[wr[EW-1:0]] <= vq;
            hmem[wr[EW-1:0]] <= hq;
            live[wr[EW-1:0]] <= 1'b1;
            if (wr != rd) live[rd[EW-1:0]] <= 1'b0;
            wr <= wr + 1'b1;
          end
          rd <= rd + 1'b1;
        end
        rhoht_pkg::S_PACK_CLR: begin
          pos <= pos + 1'b1;
          append_slot <= wr;
          rd <= '0;
          rebuilding <= 1'b1;
        end
        rhoht_pkg::S_REB_EV: begin
          cidx <= rd[EW-1:0];
          pos <= hq[BW-1:0];
          d <= '0;
          n <= '0;
        end
        rhoht_pkg::S_APPEND: begin
          rebuilding <= 1'b0;
          kmem[append_slot[EW-1:0]] <= rkey;
          vmem[append_slot[EW-1:0]] <= rval;
          hmem[append_slot[EW-1:0]] <= rhash;
          live[append_slot[EW-1:0]] <= 1'b1;
          append_slot <= append_slot + 1'b1;
          live_count <= live_count + 1'b1;
          o_status <= rhoht_pkg::ST_INSERTED;
          o_idx <= rhoht_pkg::IDX_OUT_W'({{(EW < 8 ? 8 - EW : 0){1'b0}}, append_slot[EW-1:0]});
          cidx <= append_slot[EW-1:0];
          pos <= rhash[BW-1:0];
          d <= '0;
          n <= '0;
        end
        rhoht_pkg::S_PLACE_EV: begin
          if (!bq.valid) begin
            if (rebuilding) rd <= rd + 1'b1;
          end else begin
            if (bq.probe < d) begin
              cidx <= bq.idx;
              d <= bq.probe + 1'b1;
            end else begin
              d <= d + 1'b1;
            end
            n <= n + 1'b1;
            pos <= pos + 1'b1;
            if (n == DW'(BUCKET_COUNT - 1) && rebuilding) rd <= rd + 1'b1;
          end
        end
        rhoht_pkg::S_DEL_EV: begin
          prev <= pos;
          pos <= pos + 1'b1;
          n <= n + 1'b1;
        end
        rhoht_pkg::S_CLEAR: begin
          pos <= pos + 1'b1;
          if (pos == BW'(BUCKET_COUNT - 1)) begin
            live <= '0;
            append_slot <= '0;
            live_count <= '0;
            o_status <= rhoht_pkg::ST_CLEARED;
          end
        end
        rhoht_pkg::S_INIT: pos <= pos + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhoht_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req.ready = (state == rhoht_pkg::S_IDLE);
  assign rsp.valid = (state == rhoht_pkg::S_OUT);
  assign rsp.status = o_status;
  assign rsp.entry_index = o_idx;
  assign rsp.old_value = o_old;

  `RH_ASSERT(a_live_bound, clk, rst, live_count <= append_slot || state != rhoht_pkg::S_IDLE, "live count above append slot")
  `RH_ASSERT(a_one_side, clk, rst, !(req.ready && rsp.valid), "ready while word pending")
  `RH_ASSERT(a_out_hold, clk, rst, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status), "result word dropped")
  `RH_ASSERT(a_append_cap, clk, rst, append_slot <= CW'(ENTRY_SLOTS), "append slot overrun")
endmodule

// ===== tb/robin_hood_ordered_hash_table_core_tb.sv =====
`timescale 1ns / 100ps
module robin_hood_ordered_hash_table_core_tb;

  localparam int SLOTS = 256;
  localparam int BUCKETS = 512;
  localparam int POOL = 320;

  typedef struct {
    rhoht_pkg::req_t op;
    logic [63:0] key;
    logic [31:0] hash;
    logic [63:0] value;
  } map_req_t;

  typedef struct {
    rhoht_pkg::status_t status;
    logic [7:0] index;
    logic [63:0] old_value;
  } map_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhoht_req_if req_bus();
  rhoht_rsp_if rsp_bus();

  robin_hood_ordered_hash_table_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #2 clk = ~clk;

  // shadow map
  bit bkt_valid [BUCKETS];
  int unsigned bkt_dist [BUCKETS];
  int unsigned bkt_idx [BUCKETS];
  logic [63:0] ent_key [SLOTS];
  logic [63:0] ent_val [SLOTS];
  logic [31:0] ent_hash [SLOTS];
  bit ent_live [SLOTS];
  int unsigned append_ptr;
  int unsigned live_total;

  map_req_t pending [$];
  map_rsp_t expected [$];
  logic [63:0] pool_key [POOL];
  logic [31:0] pool_hash [POOL];
  int errors = 0;
  int status_seen [8];
  int words_sent = 0;
  int words_checked = 0;

  function automatic bit lookup(logic [63:0] k, logic [31:0] h, output int unsigned where);
    int unsigned pos;
    int unsigned d;
    pos = h & (BUCKETS - 1);
    d = 0;
    where = 0;
    for (int n = 0; n < BUCKETS; n++) begin
      if (!bkt_valid[pos] || d > bkt_dist[pos]) return 1'b0;
      if (ent_hash[bkt_idx[pos]] == h && ent_key[bkt_idx[pos]] == k) begin
        where = pos;
        return 1'b1;
      end
      d++;
      pos = (pos + 1) & (BUCKETS - 1);
    end
    return 1'b0;
  endfunction

  function automatic void place(int unsigned idx, logic [31:0] h);
    int unsigned pos;
    int unsigned d;
    int unsigned td;
    int unsigned ti;
    pos = h & (BUCKETS - 1);
    d = 0;
    for (int n = 0; n < BUCKETS; n++) begin
      if (!bkt_valid[pos]) begin
        bkt_valid[pos] = 1'b1;
        bkt_dist[pos] = d;
        bkt_idx[pos] = idx;
        return;
      end
      if (bkt_dist[pos] < d) begin
        td = bkt_dist[pos];
        ti = bkt_idx[pos];
        bkt_dist[pos] = d;
        bkt_idx[pos] = idx;
        d = td;
        idx = ti;
      end
      d++;
      pos = (pos + 1) & (BUCKETS - 1);
    end
  endfunction

  function automatic void empty_buckets();
    for (int b = 0; b < BUCKETS; b++) begin
      bkt_valid[b] = 1'b0;
      bkt_dist[b] = 0;
      bkt_idx[b] = 0;
    end
  endfunction

  function automatic void compact();
    int unsigned w;
    w = 0;
    for (int r = 0; r < append_ptr && r < SLOTS; r++) begin
      if (ent_live[r]) begin
        ent_key[w] = ent_key[r];
        ent_val[w] = ent_val[r];
        ent_hash[w] = ent_hash[r];
        ent_live[w] = 1'b1;
        w++;
      end
    end
    for (int r = w; r < SLOTS; r++) ent_live[r] = 1'b0;
    append_ptr = w;
    empty_buckets();
    for (int r = 0; r < w; r++) place(r, ent_hash[r]);
  endfunction

  function automatic map_rsp_t apply_request(map_req_t q);
    map_rsp_t o;
    int unsigned pos;
    int unsigned i;
    int unsigned prev;
    int unsigned cur;
    o.status = rhoht_pkg::ST_NOT_FOUND;
    o.index = '0;
    o.old_value = '0;
    case (q.op)
      rhoht_pkg::REQ_PUT: begin
        if (lookup(q.key, q.hash, pos)) begin
          i = bkt_idx[pos];
          o.old_value = ent_val[i];
          ent_val[i] = q.value;
          o.status = rhoht_pkg::ST_REPLACED;
          o.index = i[7:0];
        end else if (live_total >= SLOTS || live_total >= BUCKETS) begin
          o.status = rhoht_pkg::ST_FULL;
        end else begin
          if (append_ptr >= SLOTS) compact();
          i = append_ptr;
          ent_key[i] = q.key;
          ent_val[i] = q.value;
          ent_hash[i] = q.hash;
          ent_live[i] = 1'b1;
          append_ptr++;
          place(i, q.hash);
          live_total++;
          o.status = rhoht_pkg::ST_INSERTED;
          o.index = i[7:0];
        end
      end
      rhoht_pkg::REQ_REMOVE: begin
        if (live_total != 0 && lookup(q.key, q.hash, pos)) begin
          i = bkt_idx[pos];
          o.old_value = ent_val[i];
          ent_live[i] = 1'b0;
          live_total--;
          o.status = rhoht_pkg::ST_REMOVED;
          o.index = i[7:0];
          bkt_valid[pos] = 1'b0;
          bkt_dist[pos] = 0;
          bkt_idx[pos] = 0;
          prev = pos;
          cur = (pos + 1) & (BUCKETS - 1);
          for (int n = 1; n < BUCKETS; n++) begin
            if (!bkt_valid[cur] || bkt_dist[cur] == 0) break;
            bkt_valid[prev] = 1'b1;
            bkt_dist[prev] = bkt_dist[cur] - 1;
            bkt_idx[prev] = bkt_idx[cur];
            bkt_valid[cur] = 1'b0;
            bkt_dist[cur] = 0;
            bkt_idx[cur] = 0;
            prev = cur;
            cur = (cur + 1) & (BUCKETS - 1);
          end
        end
      end
      rhoht_pkg::REQ_CLEAR: begin
        empty_buckets();
        for (int r = 0; r < SLOTS; r++) ent_live[r] = 1'b0;
        append_ptr = 0;
        live_total = 0;
        o.status = rhoht_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void push_req(rhoht_pkg::req_t op, logic [63:0] k, logic [31:0] h,
                                   logic [63:0] v);
    map_req_t q;
    q.op = op;
    q.key = k;
    q.hash = h;
    q.value = v;
    pending.push_back(q);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // driver
  int unsigned req_gap = 0;
  bit req_burst = 1'b0;
  map_req_t cur_req;

  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      req_bus.req_type <= rhoht_pkg::REQ_NONE;
      req_bus.key <= '0;
      req_bus.key_hash <= '0;
      req_bus.value <= '0;
      req_gap <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected.push_back(apply_request(cur_req));
        words_sent++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_req = pending.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.req_type <= cur_req.op;
          req_bus.key <= cur_req.key;
          req_bus.key_hash <= cur_req.hash;
          req_bus.value <= cur_req.value;
          if ($urandom_range(0, 63) == 0) req_burst = ~req_burst;
          req_gap <= req_burst ? 0 : $urandom_range(0, 15);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned rsp_stall = 0;
  bit rsp_burst = 1'b0;
  map_rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        words_checked++;
        if (expected.size() == 0) begin
          $error("unexpected word: status %0d", rsp_bus.status);
          errors++;
        end else begin
          want = expected.pop_front();
          status_seen[want.status]++;
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            errors++;
          end
          if (rsp_bus.entry_index !== want.index) begin
            $error("entry_index: expected %0d, got %0d", want.index, rsp_bus.entry_index);
            errors++;
          end
          if (rsp_bus.old_value !== want.old_value) begin
            $error("old_value: expected %h, got %h", want.old_value, rsp_bus.old_value);
            errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) rsp_burst = ~rsp_burst;
        if (rsp_burst) begin
          rsp_bus.ready <= 1'b1;
        end else begin
          rsp_stall <= $urandom_range(0, 15);
          rsp_bus.ready <= 1'b0;
        end
      end else if (rsp_stall != 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned sel;
    bit heavy;
    empty_buckets();
    for (int r = 0; r < SLOTS; r++) begin
      ent_live[r] = 1'b0;
      ent_key[r] = '0;
      ent_val[r] = '0;
      ent_hash[r] = '0;
    end
    append_ptr = 0;
    live_total = 0;
    for (int s = 0; s < 8; s++) status_seen[s] = 0;
    for (int n = 0; n < POOL; n++) begin
      pool_key[n] = rand64();
      if ($urandom_range(0, 9) < 3)
        pool_hash[n] = {23'($urandom_range(0, 2**23 - 1)), 9'(500 + $urandom_range(0, 11))};
      else
        pool_hash[n] = $urandom;
    end

    // directed
    push_req(rhoht_pkg::REQ_REMOVE, 64'd0, 32'd0, 64'd0);
    push_req(rhoht_pkg::REQ_PUT, 64'd0, 32'd0, 64'd0);
    push_req(rhoht_pkg::REQ_PUT, '1, '1, '1);
    push_req(rhoht_pkg::REQ_PUT, 64'h5, 32'h1FF, 64'h1234);
    push_req(rhoht_pkg::REQ_PUT, 64'h6, 32'h1FF, 64'h5678);
    push_req(rhoht_pkg::REQ_PUT, 64'h7, 32'h3FF, 64'h9ABC);
    push_req(rhoht_pkg::REQ_PUT, 64'h8, 32'h000, 64'hDEF0);
    push_req(rhoht_pkg::REQ_PUT, 64'h6, 32'h1FF, '1);
    push_req(rhoht_pkg::REQ_PUT, '1, '1, 64'd0);
    push_req(rhoht_pkg::REQ_PUT, 64'h6, 32'h0FF, 64'h1);
    push_req(rhoht_pkg::REQ_REMOVE, 64'h5, 32'h1FF, 64'd0);
    push_req(rhoht_pkg::REQ_REMOVE, 64'h5, 32'h1FF, 64'd0);
    push_req(rhoht_pkg::REQ_REMOVE, 64'h7, 32'h1FF, 64'd0);
    push_req(rhoht_pkg::REQ_PUT, 64'h5, 32'h1FF, 64'h42);
    push_req(rhoht_pkg::REQ_NONE, '1, '1, '1);
    push_req(rhoht_pkg::REQ_REMOVE, 64'd0, 32'd0, 64'd0);
    push_req(rhoht_pkg::REQ_CLEAR, '1, '1, '1);
    push_req(rhoht_pkg::REQ_REMOVE, 64'h6, 32'h1FF, 64'd0);
    push_req(rhoht_pkg::REQ_PUT, 64'h6, 32'h1FF, 64'h77);
    push_req(rhoht_pkg::REQ_CLEAR, 64'd0, 32'd0, 64'd0);

    // random: alternate put-heavy phases (fill, full, packing) with balanced churn
    heavy = 1'b1;
    for (int n = 0; n < 1800; n++) begin
      if (n % 300 == 0) heavy = ~heavy;
      p = $urandom_range(0, POOL - 1);
      sel = $urandom_range(0, 199);
      if (sel < 1)
        push_req(rhoht_pkg::REQ_CLEAR, rand64(), $urandom, rand64());
      else if (sel < 3)
        push_req(rhoht_pkg::REQ_NONE, rand64(), $urandom, rand64());
      else if (sel < 9)
        push_req(rhoht_pkg::req_t'($urandom_range(0, 1)), rand64(), $urandom, rand64());
      else if (sel < 13)
        push_req(rhoht_pkg::req_t'($urandom_range(0, 1)), pool_key[p], pool_hash[p] ^ 32'h200,
                 rand64());
      else if (sel < (heavy ? 170 : 110))
        push_req(rhoht_pkg::REQ_PUT, pool_key[p], pool_hash[p], rand64());
      else
        push_req(rhoht_pkg::REQ_REMOVE, pool_key[p], pool_hash[p], rand64());
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (pending.size() == 0 && !req_bus.valid && expected.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d requests, %0d responses: inserted %0d replaced %0d removed %0d",
             words_sent, words_checked, status_seen[rhoht_pkg::ST_INSERTED],
             status_seen[rhoht_pkg::ST_REPLACED], status_seen[rhoht_pkg::ST_REMOVED]);
    $display("not found %0d, full %0d, cleared %0d", status_seen[rhoht_pkg::ST_NOT_FOUND],
             status_seen[rhoht_pkg::ST_FULL], status_seen[rhoht_pkg::ST_CLEARED]);
    if (errors == 0 && expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rhoht_pkg.sv
hw/rtl/rhoht_req_if.sv
hw/rtl/rhoht_rsp_if.sv
hw/rtl/robin_hood_ordered_hash_table_core.sv
tb/robin_hood_ordered_hash_table_core_tb.sv
